[rtl/core/dgr_pkg.sv]
`default_nettype none

package dgr_pkg;

  localparam int MAP_BITS  = 6;
  localparam int MAP_SIZE  = 1 << MAP_BITS;
  localparam int ADDR_BITS = 2 * MAP_BITS;
  localparam int MAP_DEPTH = 1 << ADDR_BITS;
  localparam int FRAC_BITS = 8;
  localparam int POS_BITS  = 14;
  localparam int ANG_BITS  = 10;
  localparam int KIND_BITS = 4;
  localparam int DIST_BITS = 16;
  // side distances in Q16; at most about 2 * MAP_SIZE steps of under 2^32 each
  localparam int SD_BITS   = 40;
  localparam int DELTA_BITS = 32;
  localparam int SIN_BITS  = 15;
  localparam int QTR_STEPS = 256;
  localparam int IDX_BITS  = 9;
  localparam int COORD_BITS = MAP_BITS + 2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  localparam logic SIDE_X = 1'b0;
  localparam logic SIDE_Y = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_INIT,
    ST_STEP,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef logic [SIN_BITS-1:0]   sine_tab_t  [0:QTR_STEPS];
  typedef logic [DELTA_BITS-1:0] delta_tab_t [0:QTR_STEPS];

  // quarter-wave sine in Q14, odd degree-9 polynomial in Q30, truncating products
  function automatic logic [SIN_BITS-1:0] quarter_sine(input int idx);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] acc;
    logic [63:0] r;
    u   = 64'(idx) << (30 - 8);
    u2  = (u * u) >> 30;
    acc = 64'd172271;
    acc = 64'd5026995 - ((acc * u2) >> 30);
    acc = 64'd85569306 - ((acc * u2) >> 30);
    acc = 64'd693598668 - ((acc * u2) >> 30);
    acc = 64'd1686629713 - ((acc * u2) >> 30);
    r   = (acc * u) >> 30;
    r   = (r + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return SIN_BITS'(r);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int i = 0; i <= QTR_STEPS; i++) begin
      tab[i] = quarter_sine(i);
    end
    return tab;
  endfunction

  // 2^30 / s by restoring long division, s nonzero
  function automatic logic [DELTA_BITS-1:0] recip_q30(input logic [63:0] s);
    logic [63:0]           rem;
    logic [DELTA_BITS-1:0] q;
    rem = '0;
    q   = '0;
    for (int b = 30; b >= 0; b--) begin
      rem = {rem[62:0], b == 30};
      if (rem >= s) begin
        rem  = rem - s;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2^30 / |d|, largest value for a zero component
  function automatic delta_tab_t build_delta();
    delta_tab_t tab;
    logic [63:0] s;
    for (int i = 0; i <= QTR_STEPS; i++) begin
      s = 64'(quarter_sine(i));
      if (s == 64'd0) begin
        tab[i] = '1;
      end else begin
        tab[i] = recip_q30(s);
      end
    end
    return tab;
  endfunction

  localparam sine_tab_t  SINE_TAB  = build_sine();
  localparam delta_tab_t DELTA_TAB = build_delta();

  // table index of |sin| for an angle; odd quadrants run the table backward
  function automatic logic [IDX_BITS-1:0] sine_index(input logic [ANG_BITS-1:0] ang);
    logic [IDX_BITS-1:0] low;
    low = {1'b0, ang[ANG_BITS-3:0]};
    return ang[ANG_BITS-2] ? IDX_BITS'(QTR_STEPS) - low : low;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dgr_ram.sv]
`default_nettype none

module dgr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/dda_grid_raycaster_top.sv]
// Grid ray caster over a 64 x 64 map of 4-bit wall types held in one RAM.
// A map write is taken in the idle state. A ray cast runs setup and init, then
// a step and a test per cell crossed (RAM read and test of each new cell, no test
// once the step leaves the map), then a done state that loads the result; the
// cell walk reads each new cell through the single map RAM read port. One item is
// worked on at a time; the finished result sits in an output register so the
// next item can be taken while it waits. After reset a clearing pass writes
// every map cell to empty while stall stays high.
`default_nettype none

module dda_grid_raycaster_top
  import dgr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 action,
  input  wire logic [MAP_BITS-1:0]  cell_x,
  input  wire logic [MAP_BITS-1:0]  cell_y,
  input  wire logic [KIND_BITS-1:0] cell_value,
  input  wire logic [POS_BITS-1:0]  pos_x,
  input  wire logic [POS_BITS-1:0]  pos_y,
  input  wire logic [ANG_BITS-1:0]  heading,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [DIST_BITS-1:0]      wall_distance,
  output logic                      hit_side,
  output logic [KIND_BITS-1:0]      wall_kind,
  output logic                      out_of_map
);

  state_t state, state_next;

  logic [ADDR_BITS:0] clr_count;

  logic [POS_BITS-1:0] px, py;
  logic [ANG_BITS-1:0] ang;

  logic                  neg_x, neg_y;
  logic [DELTA_BITS-1:0] ddx, ddy;
  logic [FRAC_BITS:0]    frac_x, frac_y;
  logic [SD_BITS-1:0]    sdx, sdy, hit_dist;
  logic signed [COORD_BITS-1:0] mx, my;
  logic                  side;
  logic                  oom;
  logic [KIND_BITS-1:0]  kind;

  logic                  in_xfer;
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [KIND_BITS-1:0]  ram_wdata;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [KIND_BITS-1:0]  ram_rdata;

  logic [ANG_BITS-1:0]   ang_cos;
  logic [IDX_BITS-1:0]   idx_x, idx_y;
  logic [SIN_BITS-1:0]   mag_x, mag_y;

  logic                  take_x;
  logic signed [COORD_BITS-1:0] nmx, nmy;
  logic                  step_out;
  logic                  out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // direction lookup: cos is sin a quarter turn ahead
  assign ang_cos = ang + ANG_BITS'(QTR_STEPS);
  assign idx_x   = sine_index(ang_cos);
  assign idx_y   = sine_index(ang);
  assign mag_x   = SINE_TAB[idx_x];
  assign mag_y   = SINE_TAB[idx_y];

  // one DDA step; ties cross the y boundary
  assign take_x   = sdx < sdy;
  assign nmx      = take_x ? (neg_x ? mx - COORD_BITS'(1) : mx + COORD_BITS'(1)) : mx;
  assign nmy      = take_x ? my : (neg_y ? my - COORD_BITS'(1) : my + COORD_BITS'(1));
  assign step_out = (nmx[COORD_BITS-1:MAP_BITS] != '0) ||
                    (nmy[COORD_BITS-1:MAP_BITS] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = {cell_y, cell_x};
    ram_wdata  = cell_value;
    ram_raddr  = {nmy[MAP_BITS-1:0], nmx[MAP_BITS-1:0]};
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_count[ADDR_BITS-1:0];
        ram_wdata = '0;
        if (clr_count == (ADDR_BITS+1)'(MAP_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (action == ACT_WRITE) begin
            ram_we = 1'b1;
          end else begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_SETUP: state_next = ST_INIT;
      ST_INIT:  state_next = ST_STEP;
      ST_STEP: begin
        state_next = step_out ? ST_DONE : ST_CHECK;
      end
      ST_CHECK: begin
        state_next = (ram_rdata != '0) ? ST_DONE : ST_STEP;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_count <= '0;
    end else if (state == ST_CLEAR) begin
      clr_count <= clr_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        px  <= pos_x;
        py  <= pos_y;
        ang <= heading;
      end
      ST_SETUP: begin
        neg_x  <= ang_cos[ANG_BITS-1] && (mag_x != '0);
        neg_y  <= ang[ANG_BITS-1] && (mag_y != '0);
        ddx    <= DELTA_TAB[idx_x];
        ddy    <= DELTA_TAB[idx_y];
        frac_x <= (ang_cos[ANG_BITS-1] && (mag_x != '0)) ? {1'b0, px[FRAC_BITS-1:0]} :
                  (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, px[FRAC_BITS-1:0]};
        frac_y <= (ang[ANG_BITS-1] && (mag_y != '0)) ? {1'b0, py[FRAC_BITS-1:0]} :
                  (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, py[FRAC_BITS-1:0]};
        // origin cell always lies inside the map for this position width
        mx       <= COORD_BITS'(px[POS_BITS-1:FRAC_BITS]);
        my       <= COORD_BITS'(py[POS_BITS-1:FRAC_BITS]);
        side     <= SIDE_X;
        oom      <= 1'b0;
        kind     <= '0;
        hit_dist <= '0;
      end
      ST_INIT: begin
        sdx <= SD_BITS'((SD_BITS'(frac_x) * SD_BITS'(ddx)) >> FRAC_BITS);
        sdy <= SD_BITS'((SD_BITS'(frac_y) * SD_BITS'(ddy)) >> FRAC_BITS);
      end
      ST_STEP: begin
        if (take_x) begin
          hit_dist <= sdx;
          sdx      <= sdx + SD_BITS'(ddx);
          side     <= SIDE_X;
        end else begin
          hit_dist <= sdy;
          sdy      <= sdy + SD_BITS'(ddy);
          side     <= SIDE_Y;
        end
        mx  <= nmx;
        my  <= nmy;
        oom <= step_out;
      end
      ST_CHECK: begin
        kind <= ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      // Q16 to Q8.8, saturating
      if (hit_dist[SD_BITS-1:DIST_BITS+(16-FRAC_BITS)] != '0) begin
        wall_distance <= '1;
      end else begin
        wall_distance <= hit_dist[DIST_BITS+(16-FRAC_BITS)-1:16-FRAC_BITS];
      end
      hit_side   <= side;
      wall_kind  <= oom ? '0 : kind;
      out_of_map <= oom;
    end
  end

  dgr_ram #(
    .WIDTH(KIND_BITS),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> in_stall)
    else $error("transfer taken during map clear");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside done state");

  a_map_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || (state == ST_IDLE && in_xfer && action == ACT_WRITE)))
    else $error("map written during a cast");

  a_check_after_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> $past(state) == ST_STEP)
    else $error("cell test without a step");

endmodule

`default_nettype wire
